[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
		else $error("assertion failed: implication");

`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

[src/mat4_pkg.sv]
// ----------------------------------------------------------------------------
// mat4_pkg
// Shared constants and types for the 4x4 matrix multiplier.
// ----------------------------------------------------------------------------
package mat4_pkg;

	localparam int FIELD_W = 32;
	localparam int ROWS    = 4;

	typedef logic [1:0] col_idx_t;

	localparam col_idx_t LAST_COL = 2'd3;

	// control that travels alongside the lane datapath
	typedef struct packed {
		logic valid;
		logic last;
	} pipe_ctrl_t;

endpackage

[src/mat4_in_if.sv]
// ----------------------------------------------------------------------------
// mat4_in_if
// Operand channel: one column of the left and of the right matrix.
// ----------------------------------------------------------------------------
interface mat4_in_if;

	logic                                 valid;
	logic                                 ready;
	logic signed [mat4_pkg::FIELD_W-1:0] left_row0;
	logic signed [mat4_pkg::FIELD_W-1:0] left_row1;
	logic signed [mat4_pkg::FIELD_W-1:0] left_row2;
	logic signed [mat4_pkg::FIELD_W-1:0] left_row3;
	logic signed [mat4_pkg::FIELD_W-1:0] right_row0;
	logic signed [mat4_pkg::FIELD_W-1:0] right_row1;
	logic signed [mat4_pkg::FIELD_W-1:0] right_row2;
	logic signed [mat4_pkg::FIELD_W-1:0] right_row3;

	modport source (
		output valid, left_row0, left_row1, left_row2, left_row3,
		output right_row0, right_row1, right_row2, right_row3,
		input  ready
	);

	modport sink (
		input  valid, left_row0, left_row1, left_row2, left_row3,
		input  right_row0, right_row1, right_row2, right_row3,
		output ready
	);

endinterface

[src/mat4_out_if.sv]
// ----------------------------------------------------------------------------
// mat4_out_if
// Result channel: one product column with last and saturation flags.
// ----------------------------------------------------------------------------
interface mat4_out_if;

	logic                                 valid;
	logic                                 ready;
	logic signed [mat4_pkg::FIELD_W-1:0] prod_row0;
	logic signed [mat4_pkg::FIELD_W-1:0] prod_row1;
	logic signed [mat4_pkg::FIELD_W-1:0] prod_row2;
	logic signed [mat4_pkg::FIELD_W-1:0] prod_row3;
	logic                                 last_column;
	logic                                 clipped;

	modport source (
		output valid, prod_row0, prod_row1, prod_row2, prod_row3,
		output last_column, clipped,
		input  ready
	);

	modport sink (
		input  valid, prod_row0, prod_row1, prod_row2, prod_row3,
		input  last_column, clipped,
		output ready
	);

endinterface

[src/matrix4x4_multiply.sv]
// ----------------------------------------------------------------------------
// matrix4x4_multiply
// 4x4 column-major fixed-point matrix product, prod = left * right.
//
//   channel    dir  modport  transfer carries
//   --------   ---  -------  -----------------------------------------------
//   operands   in   sink     column c of left and right, c = 0,1,2,3 in turn
//   product    out  source   one product column, last_column on column 3
//
// Four column loads fill the operand store; the fourth starts the issue of
// product columns, one per cycle through four row lanes unless product
// stalls, during which operands.ready is low. Each column passes the lane
// registers (products, pair sums, saturated result) into the output reg.
// A stall on product freezes the issue and the lanes; loading the next
// matrix resumes as soon as the last column has been issued.
// Reset clears counters, busy and valid/last flags only; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix4x4_multiply #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	mat4_in_if.sink     operands,
	mat4_out_if.source  product
);

	localparam int ROWS = mat4_pkg::ROWS;

	logic signed [DATA_WIDTH-1:0] left_q  [ROWS][ROWS];  // [column][row]
	logic signed [DATA_WIDTH-1:0] right_q [ROWS][ROWS];  // [column][row]
	logic signed [DATA_WIDTH-1:0] in_left  [ROWS];
	logic signed [DATA_WIDTH-1:0] in_right [ROWS];
	logic signed [DATA_WIDTH-1:0] lane_a [ROWS][ROWS];
	logic signed [DATA_WIDTH-1:0] lane_b [ROWS];
	logic        [DATA_WIDTH-1:0] lane_res [ROWS];
	logic        [ROWS-1:0]       lane_clip;

	mat4_pkg::col_idx_t   col_q;
	mat4_pkg::col_idx_t   issue_col_q;
	logic                 issue_busy_q;
	logic                 in_xfer;
	logic                 en;
	mat4_pkg::pipe_ctrl_t ctrl_s1, ctrl_s2, ctrl_s3;

	assign operands.ready = !issue_busy_q;
	assign in_xfer        = operands.valid && operands.ready;

	assign in_left[0]  = operands.left_row0[DATA_WIDTH-1:0];
	assign in_left[1]  = operands.left_row1[DATA_WIDTH-1:0];
	assign in_left[2]  = operands.left_row2[DATA_WIDTH-1:0];
	assign in_left[3]  = operands.left_row3[DATA_WIDTH-1:0];
	assign in_right[0] = operands.right_row0[DATA_WIDTH-1:0];
	assign in_right[1] = operands.right_row1[DATA_WIDTH-1:0];
	assign in_right[2] = operands.right_row2[DATA_WIDTH-1:0];
	assign in_right[3] = operands.right_row3[DATA_WIDTH-1:0];

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			left_q[col_q]  <= in_left;
			right_q[col_q] <= in_right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			issue_col_q  <= '0;
			issue_busy_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				col_q <= col_q + 2'd1;
				if (col_q == mat4_pkg::LAST_COL) begin
					issue_busy_q <= 1'b1;
					issue_col_q  <= '0;
				end
			end else if (issue_busy_q && en) begin
				issue_col_q <= issue_col_q + 2'd1;
				if (issue_col_q == mat4_pkg::LAST_COL) begin
					issue_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else if (en) begin
			ctrl_s1.valid <= issue_busy_q;
			ctrl_s1.last  <= issue_col_q == mat4_pkg::LAST_COL;
			ctrl_s2       <= ctrl_s1;
			ctrl_s3       <= ctrl_s2;
		end
	end

	// lane i sees left row i; all lanes share the right column being issued
	for (genvar i = 0; i < ROWS; i++) begin : g_lane
		for (genvar k = 0; k < ROWS; k++) begin : g_tap
			assign lane_a[i][k] = left_q[k][i];
		end
		assign lane_b[i] = right_q[issue_col_q][i];

		mat4_lane #(
			.DATA_WIDTH (DATA_WIDTH),
			.FRAC_BITS  (FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.en     (en),
			.a      (lane_a[i]),
			.b      (lane_b),
			.result (lane_res[i]),
			.clip   (lane_clip[i])
		);
	end

	mat4_merge #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl_s3   (ctrl_s3),
		.lane_res  (lane_res),
		.lane_clip (lane_clip),
		.en        (en),
		.product   (product)
	);

	`ASSERT_NEXT(a_issue_starts, clk, arst_n, in_xfer && col_q == mat4_pkg::LAST_COL, issue_busy_q && issue_col_q == '0)
	`ASSERT_NEXT(a_issue_ends, clk, arst_n, issue_busy_q && en && issue_col_q == mat4_pkg::LAST_COL, !issue_busy_q && ctrl_s1.valid && ctrl_s1.last)
	`ASSERT_IMPLIES(a_count_wrapped, clk, arst_n, issue_busy_q, col_q == '0)

endmodule

[src/mat4_lane.sv]
// ----------------------------------------------------------------------------
// mat4_lane
// One result row: four-term dot product, floor shift and saturation,
// three register stages, all advancing on en.
// ----------------------------------------------------------------------------
module mat4_lane #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [DATA_WIDTH-1:0] a [mat4_pkg::ROWS],
	input  logic signed [DATA_WIDTH-1:0] b [mat4_pkg::ROWS],
	output logic        [DATA_WIDTH-1:0] result,
	output logic                         clip
);

	localparam int PROD_W = 2 * DATA_WIDTH;
	localparam int SUM_W  = PROD_W + 2;
	localparam int HEAD_W = SUM_W - DATA_WIDTH + 1;

	localparam logic [DATA_WIDTH-1:0] POS_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] NEG_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic signed [PROD_W-1:0] prod_s1 [mat4_pkg::ROWS];
	logic signed [SUM_W-1:0]  sum01_s2;
	logic signed [SUM_W-1:0]  sum23_s2;
	logic signed [SUM_W-1:0]  total;
	logic signed [SUM_W-1:0]  shifted;
	logic        [HEAD_W-1:0] head;
	logic        [DATA_WIDTH-1:0] result_s3;
	logic                     clip_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < mat4_pkg::ROWS; k++) begin
				prod_s1[k] <= PROD_W'(a[k]) * PROD_W'(b[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum01_s2 <= SUM_W'(prod_s1[0]) + SUM_W'(prod_s1[1]);
			sum23_s2 <= SUM_W'(prod_s1[2]) + SUM_W'(prod_s1[3]);
		end
	end

	// arithmetic shift gives floor; in range when all head bits agree
	assign total   = sum01_s2 + sum23_s2;
	assign shifted = total >>> FRAC_BITS;
	assign head    = shifted[SUM_W-1:DATA_WIDTH-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if ((&head) || !(|head)) begin
				result_s3 <= shifted[DATA_WIDTH-1:0];
				clip_s3   <= 1'b0;
			end else begin
				result_s3 <= shifted[SUM_W-1] ? NEG_MIN : POS_MAX;
				clip_s3   <= 1'b1;
			end
		end
	end

	assign result = result_s3;
	assign clip   = clip_s3;

endmodule

[src/mat4_merge.sv]
// ----------------------------------------------------------------------------
// mat4_merge
// Gathers the four lane results into one product column, folds the lane
// saturation flags and holds the column in the output register.
// ----------------------------------------------------------------------------
module mat4_merge #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mat4_pkg::pipe_ctrl_t        ctrl_s3,
	input  logic [DATA_WIDTH-1:0]       lane_res [mat4_pkg::ROWS],
	input  logic [mat4_pkg::ROWS-1:0]   lane_clip,
	output logic                        en,
	mat4_out_if.source                  product
);

	logic                      valid_q;
	logic                      last_q;
	logic                      clipped_q;
	logic [DATA_WIDTH-1:0]     res_q [mat4_pkg::ROWS];

	// the whole pipeline moves when the output register is free
	assign en = !valid_q || product.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctrl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctrl_s3.valid) begin
			last_q    <= ctrl_s3.last;
			clipped_q <= |lane_clip;
			res_q     <= lane_res;
		end
	end

	assign product.valid       = valid_q;
	assign product.prod_row0   = mat4_pkg::FIELD_W'(res_q[0]);
	assign product.prod_row1   = mat4_pkg::FIELD_W'(res_q[1]);
	assign product.prod_row2   = mat4_pkg::FIELD_W'(res_q[2]);
	assign product.prod_row3   = mat4_pkg::FIELD_W'(res_q[3]);
	assign product.last_column = last_q;
	assign product.clipped     = clipped_q;

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for matrix4x4_multiply. Whole matrices go in as four
// operand column transfers. An internal fixed-point product model predicts the
// four product columns, and each product transfer is checked against them in
// order. Covered: identity, saturation both ways, floor on the fraction shift,
// partial clipping, random matrices with random gaps on both channels, back-to-back
// matrices, and a long output stall that backs up the operand channel.
// ----------------------------------------------------------------------------
module tb;

	localparam int FIELD_W      = mat4_pkg::FIELD_W;
	localparam int ROWS         = mat4_pkg::ROWS;
	localparam int DATA_WIDTH   = 32;
	localparam int FRAC_BITS    = 16;
	localparam int MAX_GAP      = 12;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 200_000;
	localparam int ACC_W        = 2 * FIELD_W + 2;

	localparam logic signed [ACC_W-1:0] ELEM_MAX = (66'sd1 <<< (DATA_WIDTH - 1)) - 66'sd1;
	localparam logic signed [ACC_W-1:0] ELEM_MIN = -(66'sd1 <<< (DATA_WIDTH - 1));

	typedef logic [4*ROWS-1:0][FIELD_W-1:0] matrix_t;

	typedef struct packed {
		logic [ROWS-1:0][FIELD_W-1:0] left;
		logic [ROWS-1:0][FIELD_W-1:0] right;
	} operand_col_t;

	typedef struct packed {
		logic [ROWS-1:0][FIELD_W-1:0] row;
		logic                         last_column;
		logic                         clipped;
	} product_col_t;

	logic clk;
	logic arst_n;

	mat4_in_if  operands_if();
	mat4_out_if product_if();

	matrix4x4_multiply #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.operands(operands_if),
		.product (product_if)
	);

	// model state
	logic signed [FIELD_W-1:0] left_mat[4*ROWS];
	logic signed [FIELD_W-1:0] right_mat[4*ROWS];
	mat4_pkg::col_idx_t        next_col;
	product_col_t              product_columns_due[$];

	bit   idle_on;
	bit   hold_off;
	event hold_req;
	int   error_count;
	int   columns_sent;
	int   columns_checked;
	int   columns_clipped;
	int   cycle_count;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int draw_gap();
		return idle_on ? int'($urandom_range(0, MAX_GAP)) : 0;
	endfunction

	// Stores one operand column; on the fourth column queues the product.
	function automatic void store_and_predict(operand_col_t col);
		product_col_t              res;
		logic signed [ACC_W-1:0]   acc;
		logic signed [ACC_W-1:0]   a;
		logic signed [ACC_W-1:0]   b;
		for (int r = 0; r < ROWS; r++) begin
			left_mat[next_col * ROWS + r]  = col.left[r];
			right_mat[next_col * ROWS + r] = col.right[r];
		end
		if (next_col == mat4_pkg::LAST_COL) begin
			for (int j = 0; j < 4; j++) begin
				res = '0;
				res.last_column = (j == 3);
				for (int i = 0; i < ROWS; i++) begin
					acc = '0;
					for (int k = 0; k < 4; k++) begin
						a = left_mat[k * ROWS + i];
						b = right_mat[j * ROWS + k];
						acc = acc + a * b;
					end
					acc = acc >>> FRAC_BITS;
					if (acc > ELEM_MAX) begin
						acc = ELEM_MAX;
						res.clipped = 1'b1;
					end else if (acc < ELEM_MIN) begin
						acc = ELEM_MIN;
						res.clipped = 1'b1;
					end
					res.row[i] = acc[FIELD_W-1:0];
				end
				product_columns_due.push_back(res);
			end
		end
		next_col = next_col + 1'b1;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_column(operand_col_t col);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			operands_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		operands_if.valid      = 1'b1;
		operands_if.left_row0  = col.left[0];
		operands_if.left_row1  = col.left[1];
		operands_if.left_row2  = col.left[2];
		operands_if.left_row3  = col.left[3];
		operands_if.right_row0 = col.right[0];
		operands_if.right_row1 = col.right[1];
		operands_if.right_row2 = col.right[2];
		operands_if.right_row3 = col.right[3];
		forever begin
			@(posedge clk);
			if (operands_if.ready)
				break;
		end
		store_and_predict(col);
		columns_sent++;
		@(negedge clk);
	endtask

	task automatic send_matrix(matrix_t lm, matrix_t rm);
		operand_col_t col;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < ROWS; r++) begin
				col.left[r]  = lm[c * ROWS + r];
				col.right[r] = rm[c * ROWS + r];
			end
			send_column(col);
		end
	endtask

	function automatic logic [FIELD_W-1:0] rand_elem();
		logic [FIELD_W-1:0] v;
		case ($urandom_range(0, 3))
			0: v = $urandom;
			1: v = 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
			2: begin
				case ($urandom_range(0, 5))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = 32'h0000_0000;
					3: v = 32'hFFFF_FFFF;
					4: v = 32'h0001_0000;
					default: v = 32'hFFFF_0000;
				endcase
			end
			default: begin
				v = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic matrix_t rand_matrix();
		matrix_t m;
		for (int n = 0; n < 4 * ROWS; n++)
			m[n] = rand_elem();
		return m;
	endfunction

	function automatic matrix_t fill_matrix(logic [FIELD_W-1:0] v);
		matrix_t m;
		for (int n = 0; n < 4 * ROWS; n++)
			m[n] = v;
		return m;
	endfunction

	// 1.0 on the diagonal
	function automatic matrix_t unit_matrix();
		matrix_t m;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < ROWS; r++)
				m[c * ROWS + r] = (c == r) ? 32'h0001_0000 : 32'h0;
		return m;
	endfunction

	// product columns
	initial begin
		product_col_t       due;
		logic [ROWS-1:0][FIELD_W-1:0] got_rows;
		int                 stall;
		product_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				product_if.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			forever begin
				product_if.ready = !hold_off;
				@(posedge clk);
				if (product_if.valid && product_if.ready)
					break;
				@(negedge clk);
			end
			got_rows[0] = product_if.prod_row0;
			got_rows[1] = product_if.prod_row1;
			got_rows[2] = product_if.prod_row2;
			got_rows[3] = product_if.prod_row3;
			if (product_columns_due.size() == 0) begin
				$error("product transfer with no column expected");
				error_count++;
			end else begin
				due = product_columns_due.pop_front();
				for (int r = 0; r < ROWS; r++) begin
					if (got_rows[r] !== due.row[r]) begin
						$error("prod_row%0d: expected %0d, got %0d", r,
							$signed(due.row[r]), $signed(got_rows[r]));
						error_count++;
					end
				end
				if (product_if.last_column !== due.last_column) begin
					$error("last_column: expected %0b, got %0b",
						due.last_column, product_if.last_column);
					error_count++;
				end
				if (product_if.clipped !== due.clipped) begin
					$error("clipped: expected %0b, got %0b",
						due.clipped, product_if.clipped);
					error_count++;
				end
				columns_checked++;
				if (due.clipped)
					columns_clipped++;
			end
			@(negedge clk);
		end
	end

	// long output stall, counted here so the sender keeps pushing meanwhile
	initial begin
		hold_off = 1'b0;
		forever begin
			@(hold_req);
			hold_off = 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_off = 1'b0;
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	task automatic test_identity();
		idle_on = 1'b1;
		send_matrix(unit_matrix(), rand_matrix());
	endtask

	task automatic test_saturation();
		// min*min overflows high, max*min overflows low
		send_matrix(fill_matrix(32'h8000_0000), fill_matrix(32'h8000_0000));
		send_matrix(fill_matrix(32'h7FFF_FFFF), fill_matrix(32'h8000_0000));
	endtask

	task automatic test_floor_shift();
		// tiny negative sum must floor to -1, not truncate to 0
		send_matrix(fill_matrix(32'hFFFF_FFFF), fill_matrix(32'h0000_0001));
	endtask

	task automatic test_partial_clip();
		matrix_t lm;
		matrix_t rm;
		lm = unit_matrix();
		lm[0] = 32'h7FFF_FFFF;
		rm = fill_matrix(32'h0003_0000);
		rm[1 * ROWS + 0] = 32'h0;   // column 1 stays in range
		send_matrix(lm, rm);
	endtask

	task automatic test_random(int n_matrices);
		for (int m = 0; m < n_matrices; m++) begin
			if (m % 10 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			send_matrix(rand_matrix(), rand_matrix());
		end
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		for (int m = 0; m < 8; m++)
			send_matrix(rand_matrix(), rand_matrix());
	endtask

	task automatic test_output_stall();
		idle_on = 1'b0;
		-> hold_req;
		for (int m = 0; m < 3; m++)
			send_matrix(rand_matrix(), rand_matrix());
	endtask

	initial begin
		arst_n                 = 1'b0;
		idle_on                = 1'b1;
		next_col               = '0;
		error_count            = 0;
		columns_sent           = 0;
		columns_checked        = 0;
		columns_clipped        = 0;
		operands_if.valid      = 1'b0;
		operands_if.left_row0  = '0;
		operands_if.left_row1  = '0;
		operands_if.left_row2  = '0;
		operands_if.left_row3  = '0;
		operands_if.right_row0 = '0;
		operands_if.right_row1 = '0;
		operands_if.right_row2 = '0;
		operands_if.right_row3 = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_identity();
		test_saturation();
		test_floor_shift();
		test_partial_clip();
		test_random(102);
		test_back_to_back();
		test_output_stall();

		operands_if.valid = 1'b0;
		while (product_columns_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d matrix products (%0d operand columns), %0d product columns checked",
			columns_sent / 4, columns_sent, columns_checked);
		$display("%0d product columns saturated; a %0d-cycle output stall backed up the input",
			columns_clipped, HOLD_CYCLES);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/mat4_pkg.sv
src/mat4_in_if.sv
src/mat4_out_if.sv
src/mat4_lane.sv
src/mat4_merge.sv
src/matrix4x4_multiply.sv
tb/tb.sv
